/* rtl/mdrs_pkg.sv */
// package for the multibyte delimiter record splitter: constants and types
`default_nettype none

package mdrs_pkg;

    localparam int MAX_DELIM    = 8;
    localparam int GATHER_DEPTH = MAX_DELIM - 1;
    localparam int LEN_W        = 4;
    localparam int CNT_W        = $clog2(GATHER_DEPTH + 1);
    localparam int LIST_CNT_W   = $clog2(MAX_DELIM + 1);
    localparam int DATA_W       = 64;
    localparam int ADDR_W       = 4;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic REG_DELIM_LENGTH = 1'b0;
    localparam logic REG_DELIM_BYTES  = 1'b1;

    localparam logic [LEN_W-1:0] LENGTH_RESET = LEN_W'(1);
    localparam logic [DATA_W-1:0] BYTES_RESET = DATA_W'(10);

    typedef struct packed {
        logic [7:0] data;
        logic       kind;
    } result_t;

endpackage

`default_nettype wire

/* rtl/multibyte_delimiter_record_splitter_unit.sv */
// top level: splits a byte stream into records at a configurable multibyte delimiter
`default_nettype none

// One input item is taken per cycle while the result list is empty or handing out
// its last result in that cycle. An item yields zero to eight results; they are
// loaded at once into an eight-entry result list that shifts out one result per
// cycle while m_ready is high, so an item with n results holds the input side until
// its n results are taken, and an item with at most one result keeps the full rate
// of one item per cycle. The delimiter length and bytes are written over the APB port
// (length at 0x0, bytes at 0x8) only while the block is idle; the user must ensure it.
module multibyte_delimiter_record_splitter_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mdrs_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mdrs_pkg::DATA_W-1:0] pwdata,
    output logic      [mdrs_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [7:0]                  s_in_byte,
    input  wire logic                        s_end_of_input,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [7:0]                  m_out_byte,
    output logic                             m_kind,
    output logic                             m_run_last
);
    import mdrs_pkg::*;

    logic [LEN_W-1:0]      len_reg;
    logic [DATA_W-1:0]     dbytes_reg;
    logic                  collecting_reg;
    logic                  collecting_next;
    logic [CNT_W-1:0]      gcount_reg;
    logic [CNT_W-1:0]      gcount_next;
    logic                  started_reg;
    logic                  started_next;
    logic [7:0]            gathered_reg [GATHER_DEPTH];
    logic                  gwrite;
    result_t               list_reg [MAX_DELIM];
    logic [LIST_CNT_W-1:0] list_cnt_reg;

    logic                  cfg_write;
    logic [3:0]            eff_len;
    logic [3:0]            need;
    logic                  accept;
    logic                  take;
    result_t               res [MAX_DELIM];
    logic [LIST_CNT_W-1:0] res_n;

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb begin
        unique case (paddr[3])
            REG_DELIM_LENGTH: prdata = {{(DATA_W-LEN_W){1'b0}}, len_reg};
            REG_DELIM_BYTES:  prdata = dbytes_reg;
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= LENGTH_RESET;
            dbytes_reg <= BYTES_RESET;
        end else if (cfg_write) begin
            unique case (paddr[3])
                REG_DELIM_LENGTH: len_reg    <= pwdata[LEN_W-1:0];
                REG_DELIM_BYTES:  dbytes_reg <= pwdata;
                default:          len_reg    <= len_reg;
            endcase
        end
    end

    // effective length, clamped to 1..MAX_DELIM
    always_comb begin
        if (len_reg == 4'd0)
            eff_len = 4'd1;
        else if (len_reg > 4'(MAX_DELIM))
            eff_len = 4'(MAX_DELIM);
        else
            eff_len = len_reg;
        need = eff_len - 4'd1;
    end

    // handshake
    assign m_valid = (list_cnt_reg != '0);
    assign take    = m_valid & m_ready;
    assign s_ready = (list_cnt_reg == '0) || ((list_cnt_reg == LIST_CNT_W'(1)) && m_ready);
    assign accept  = s_valid & s_ready;

    assign m_out_byte = list_reg[0].data;
    assign m_kind     = list_reg[0].kind;
    assign m_run_last = (list_cnt_reg == LIST_CNT_W'(1));

    // per-item results and next state
    always_comb begin
        logic [7:0] gath_new [GATHER_DEPTH];
        logic [3:0] newcnt;
        logic       mism;

        collecting_next = collecting_reg;
        gcount_next     = gcount_reg;
        started_next    = started_reg;
        gwrite          = 1'b0;
        res_n           = '0;
        mism            = 1'b0;
        newcnt          = {1'b0, gcount_reg} + {3'd0, (gcount_reg != CNT_W'(GATHER_DEPTH))};
        for (int i = 0; i < MAX_DELIM; i++)
            res[i] = '{data: 8'd0, kind: KIND_END};
        for (int i = 0; i < GATHER_DEPTH; i++)
            gath_new[i] = (gcount_reg == CNT_W'(i)) ? s_in_byte : gathered_reg[i];

        if (s_end_of_input) begin
            if (started_reg || collecting_reg)
                res_n = LIST_CNT_W'(1);
            collecting_next = 1'b0;
            gcount_next     = '0;
            started_next    = 1'b0;
        end else if (!collecting_reg) begin
            started_next = 1'b1;
            if (s_in_byte == dbytes_reg[7:0]) begin
                if (eff_len == 4'd1) begin
                    res_n        = LIST_CNT_W'(1);
                    started_next = 1'b0;
                end else begin
                    collecting_next = 1'b1;
                    gcount_next     = '0;
                end
            end else begin
                res[0] = '{data: s_in_byte, kind: KIND_DATA};
                res_n  = LIST_CNT_W'(1);
            end
        end else begin
            gwrite      = (gcount_reg != CNT_W'(GATHER_DEPTH));
            gcount_next = newcnt[CNT_W-1:0];
            if (newcnt >= need) begin
                for (int i = 0; i < GATHER_DEPTH; i++) begin
                    if ((4'(i) < need) && (gath_new[i] != dbytes_reg[8*(i+1) +: 8]))
                        mism = 1'b1;
                end
                if (!mism) begin
                    res_n        = LIST_CNT_W'(1);
                    started_next = 1'b0;
                end else begin
                    res[0] = '{data: dbytes_reg[7:0], kind: KIND_DATA};
                    for (int i = 0; i < GATHER_DEPTH; i++)
                        res[i+1] = '{data: gath_new[i], kind: KIND_DATA};
                    res_n = newcnt + LIST_CNT_W'(1);
                end
                collecting_next = 1'b0;
                gcount_next     = '0;
            end
        end
    end

    // splitter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            gcount_reg     <= '0;
            started_reg    <= 1'b0;
        end else if (accept) begin
            collecting_reg <= collecting_next;
            gcount_reg     <= gcount_next;
            started_reg    <= started_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < GATHER_DEPTH; i++) begin
            if (accept && collecting_reg && !s_end_of_input && gwrite
                && (gcount_reg == CNT_W'(i)))
                gathered_reg[i] <= s_in_byte;
        end
    end

    // result list, entry 0 drives the output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            list_cnt_reg <= '0;
        end else if (accept && (res_n != '0)) begin
            list_cnt_reg <= res_n;
        end else if (take) begin
            list_cnt_reg <= list_cnt_reg - LIST_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (res_n != '0)) begin
            for (int i = 0; i < MAX_DELIM; i++)
                list_reg[i] <= res[i];
        end else if (take) begin
            for (int i = 0; i < MAX_DELIM - 1; i++)
                list_reg[i] <= list_reg[i+1];
        end
    end

endmodule

`default_nettype wire

/* sim/testbench.sv */
// testbench for the multibyte delimiter record splitter: stimulus, prediction and checks
`timescale 1ns / 100ps

module testbench;

    import mdrs_pkg::*;

    localparam int          LONG_HOLD   = 400;
    localparam int          SETTLE      = 16;
    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 23;
    localparam int unsigned LIMIT       = 300000;

    typedef struct packed {
        logic [7:0] data;
        logic       kind;
        logic       last;
    } split_result_t;

    class splitter_scoreboard;
        logic [LEN_W-1:0] delim_length;
        logic [63:0]      delim_bytes;
        bit               collecting;
        int               gathered_count;
        logic [7:0]       gathered [GATHER_DEPTH];
        bit               record_open;
        split_result_t    expected [$];
        split_result_t    step_out [$];
        int unsigned      items_noted;
        int unsigned      results_checked;
        int unsigned      record_ends;
        int unsigned      replays;
        int unsigned      mismatches;

        function new();
            delim_length    = LENGTH_RESET;
            delim_bytes     = BYTES_RESET;
            collecting      = 1'b0;
            gathered_count  = 0;
            record_open     = 1'b0;
            items_noted     = 0;
            results_checked = 0;
            record_ends     = 0;
            replays         = 0;
            mismatches      = 0;
        endfunction

        function int eff_length();
            int len;
            len = int'(delim_length);
            if (len < 1) len = 1;
            if (len > MAX_DELIM) len = MAX_DELIM;
            return len;
        endfunction

        function logic [7:0] delim_byte(int k);
            return delim_bytes[8*k +: 8];
        endfunction

        function void emit(logic [7:0] d, logic k);
            split_result_t r;
            r.data = d;
            r.kind = k;
            r.last = 1'b0;
            step_out.push_back(r);
        endfunction

        function void note_item(logic [7:0] b, logic eoi);
            split_result_t r;
            int            len;
            int            need;
            bit            match;
            step_out.delete();
            len = eff_length();
            items_noted++;
            if (eoi) begin
                if (record_open || collecting) emit(8'h00, KIND_END);
                collecting     = 1'b0;
                gathered_count = 0;
                record_open    = 1'b0;
            end else if (!collecting) begin
                record_open = 1'b1;
                if (b == delim_byte(0)) begin
                    if (len == 1) begin
                        emit(8'h00, KIND_END);
                        record_open = 1'b0;
                    end else begin
                        collecting     = 1'b1;
                        gathered_count = 0;
                    end
                end else begin
                    emit(b, KIND_DATA);
                end
            end else begin
                need = len - 1;
                if (gathered_count < GATHER_DEPTH) begin
                    gathered[gathered_count] = b;
                    gathered_count++;
                end
                if (gathered_count >= need) begin
                    match = 1'b1;
                    for (int i = 0; i < need; i++) begin
                        if (gathered[i] != delim_byte(i + 1)) match = 1'b0;
                    end
                    if (match) begin
                        emit(8'h00, KIND_END);
                        record_open = 1'b0;
                    end else begin
                        replays++;
                        emit(delim_byte(0), KIND_DATA);
                        for (int i = 0; i < gathered_count; i++) emit(gathered[i], KIND_DATA);
                    end
                    collecting     = 1'b0;
                    gathered_count = 0;
                end
            end
            if (step_out.size() > 0) begin
                r = step_out.pop_back();
                r.last = 1'b1;
                step_out.push_back(r);
            end
            while (step_out.size() > 0) expected.push_back(step_out.pop_front());
        endfunction

        function void check_result(logic [7:0] d, logic k, logic l);
            split_result_t want;
            results_checked++;
            if (expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t unexpected result: data %02h kind %0b last %0b",
                             $time, d, k, l);
                return;
            end
            want = expected.pop_front();
            if (want.data !== d || want.kind !== k || want.last !== l) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t mismatch: expected data %02h kind %0b last %0b, got %02h %0b %0b",
                             $time, want.data, want.kind, want.last, d, k, l);
            end else if (k == KIND_END) begin
                record_ends++;
            end
        endfunction

        function int pending();
            return expected.size();
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_valid;
    logic              s_ready;
    logic [7:0]        s_in_byte;
    logic              s_end_of_input;
    logic              m_valid;
    logic              m_ready;
    logic [7:0]        m_out_byte;
    logic              m_kind;
    logic              m_run_last;

    splitter_scoreboard sb;
    bit                 idle_on;
    bit                 hold_req;
    int                 rx_stall_left;
    int unsigned        tx_count;
    int unsigned        cycle_count = 0;

    multibyte_delimiter_record_splitter_unit i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_kind         (m_kind),
        .m_run_last     (m_run_last)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("[multibyte_delimiter_record_splitter_unit] ERROR");
            $finish;
        end
    end

    // inputs are noted before results so a same-edge pass-through still lines up
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_item(s_in_byte, s_end_of_input);
            if (m_valid && m_ready) sb.check_result(m_out_byte, m_kind, m_run_last);
        end
    end

    initial begin
        m_ready       = 1'b0;
        rx_stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req      = 1'b0;
                rx_stall_left = LONG_HOLD;
                m_ready <= 1'b0;
            end else if (rx_stall_left != 0) begin
                rx_stall_left--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                rx_stall_left = $urandom_range(0, 12);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic eoi);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_in_byte      <= b;
        s_end_of_input <= eoi;
        do @(posedge aclk); while (!s_ready);
        tx_count++;
    endtask

    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic reg_idx, input logic [DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_DELIM_LENGTH) sb.delim_length = value[LEN_W-1:0];
        else sb.delim_bytes = value;
    endtask

    initial begin
        int            preset_len [6];
        int unsigned   target;
        int            len;
        int            pick;
        int            cut;
        logic [63:0]   delim;
        bit            narrow;

        preset_len     = '{8, 1, 0, 15, 4, 2};
        sb             = new();
        idle_on        = 1'b1;
        hold_req       = 1'b0;
        tx_count       = 0;
        aresetn        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_valid        = 1'b0;
        s_in_byte      = 8'h00;
        s_end_of_input = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset delimiter: single line feed
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'h0a, 1'b0);
        send_item(8'h0a, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'h41, 1'b0);
        send_item(8'hff, 1'b1);

        wait_quiet();
        write_reg(REG_DELIM_LENGTH, 64'd3);
        write_reg(REG_DELIM_BYTES, 64'h0000_0000_0042_0a0d);
        send_item(8'h0d, 1'b0); send_item(8'h0a, 1'b0); send_item(8'h42, 1'b0);
        send_item(8'h0d, 1'b0); send_item(8'h0a, 1'b0); send_item(8'h43, 1'b0);
        send_item(8'h0d, 1'b0); send_item(8'h00, 1'b1);
        send_item(8'h0d, 1'b0); send_item(8'h0a, 1'b0);

        // shorten the delimiter while one is half gathered
        wait_quiet();
        write_reg(REG_DELIM_LENGTH, 64'd2);
        send_item(8'h55, 1'b0);

        wait_quiet();
        write_reg(REG_DELIM_LENGTH, 64'd8);
        write_reg(REG_DELIM_BYTES, 64'hffff_ffff_ffff_ffff);
        send_item(8'hff, 1'b0);
        repeat (7) send_item(8'h00, 1'b0);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_quiet();
            narrow = $urandom_range(0, 1);
            for (int k = 0; k < 8; k++)
                delim[8*k +: 8] = narrow ? 8'($urandom_range(97, 99)) : 8'($urandom_range(0, 255));
            if (ph == 1) delim = 64'hffff_ffff_ffff_ffff;
            if (ph == 2) delim = 64'h0;
            write_reg(REG_DELIM_LENGTH,
                      64'(ph < 6 ? preset_len[ph] : $urandom_range(0, 15)));
            write_reg(REG_DELIM_BYTES, delim);
            idle_on = (ph != 3) && (ph < PHASES - 2);
            if (ph == 0) hold_req = 1'b1;
            target = tx_count + PHASE_ITEMS;
            while (tx_count < target) begin
                len  = sb.eff_length();
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    send_item($urandom_range(0, 1) ? sb.delim_byte($urandom_range(0, len - 1))
                                                   : 8'($urandom_range(97, 100)), 1'b0);
                end else if (pick < 60) begin
                    for (int k = 0; k < len; k++) send_item(sb.delim_byte(k), 1'b0);
                end else if (pick < 85 && len > 1) begin
                    cut = $urandom_range(1, len - 1);
                    for (int k = 0; k < cut; k++) send_item(sb.delim_byte(k), 1'b0);
                    send_item(8'($urandom_range(0, 255)), 1'b0);
                end else if (pick < 92) begin
                    send_item(8'($urandom_range(0, 255)), 1'b1);
                end else begin
                    send_item(8'($urandom_range(0, 255)), 1'b0);
                end
            end
        end

        wait_quiet();
        $display("items in: %0d, results checked: %0d, record ends: %0d, replayed delimiters: %0d",
                 sb.items_noted, sb.results_checked, sb.record_ends, sb.replays);
        $display("%0d delimiter settings incl. lengths 0, 1, 8, 15; one %0d-cycle output hold",
                 PHASES + 4, LONG_HOLD);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[multibyte_delimiter_record_splitter_unit] OK");
        end else begin
            $display("mismatches: %0d, expected results left over: %0d",
                     sb.mismatches, sb.pending());
            $display("[multibyte_delimiter_record_splitter_unit] ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/mdrs_pkg.sv
rtl/multibyte_delimiter_record_splitter_unit.sv
sim/testbench.sv
